FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the position ring log.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Plain invariant checked on every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, (expr), msg)

`endif

FILE: design/tprl_pkg.sv
// Shared types and constants of the time-stamped position ring log.
// No dependencies; imported by every module of the block.
package tprl_pkg;

    localparam int SLOTS_DEF       = 256;
    localparam int MAX_RECORDS_DEF = 255;

    localparam int MODE_W     = 2;
    localparam int INTERVAL_W = 20;
    localparam int MIN_W      = 32;
    localparam int COORD_W    = 16;
    localparam int IDX_W      = 8;
    localparam int COMMIT_W   = 16;

    localparam logic [INTERVAL_W-1:0] SAVE_INTERVAL_RST = 20'd60;

    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AGE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OLDEST = 2'd3;

    // One log record as held in the memory.
    typedef struct packed {
        logic [COORD_W-1:0] lon;
        logic [COORD_W-1:0] lat;
        logic [COORD_W-1:0] alt;
        logic [MIN_W-1:0]   minutes;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Control of the slot walker.
    typedef struct packed {
        logic load;
        logic step;
    } t_walk_ctl;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 112;

endpackage

FILE: design/tprl_ram.sv
// Record memory of the position ring log: one write port, one registered read port.
// Depends on tprl_pkg for the record type.
module tprl_ram #(
    parameter int DEPTH = tprl_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  tprl_pkg::t_rec       i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output tprl_pkg::t_rec       o_rd_data
);
    import tprl_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/tprl_walk.sv
// Slot walker: steps a ring pointer backward from the newest slot and counts the age.
// Depends on tprl_pkg for the control struct.
module tprl_walk #(
    parameter int SLOTS  = tprl_pkg::SLOTS_DEF,
    parameter int SLOT_W = $clog2(SLOTS),
    parameter int AGE_W  = 8
) (
    input  logic                  i_clk,
    input  tprl_pkg::t_walk_ctl   i_ctl,
    input  logic [SLOT_W-1:0]     i_wr_slot,
    output logic [SLOT_W-1:0]     o_ptr,
    output logic [AGE_W-1:0]      o_age
);
    import tprl_pkg::*;

    logic [SLOT_W-1:0] r_ptr;
    logic [SLOT_W-1:0] n_ptr;
    logic [AGE_W-1:0]  r_age;
    logic [AGE_W-1:0]  n_age;

    // Step one slot back, wrapping below zero to the top slot.
    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(SLOTS - 1) : s - SLOT_W'(1);
    endfunction

    always_comb begin
        n_ptr = r_ptr;
        n_age = r_age;
        if (i_ctl.load) begin
            n_ptr = slot_dec(i_wr_slot);
            n_age = '0;
        end else if (i_ctl.step) begin
            n_ptr = slot_dec(r_ptr);
            n_age = r_age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_age <= n_age;
    end

    assign o_ptr = r_ptr;
    assign o_age = r_age;

endmodule

FILE: design/timestamped_position_ring_log.sv
// Time-stamped position ring log: input and output stream channels, one config register.
// The slave channel takes one command beat (s_axis_tuser is the mode), the master
// channel returns exactly one result beat per command (m_axis_tuser is hit).
// Modes: store a fix, read the record N back from the newest, read the oldest,
// search backward from the newest for the first record older than a given time.
// A small sequencer drives one slot walker (pointer step plus age counter) and one
// record memory with a registered read port; every mode runs through that loop.
// A store of an invalid fix goes straight to the result, a store to an empty log
// writes at once, and any other store fetches the newest record before the write.
// Read by age walks back age_index slots; read oldest walks to the last one in the
// count; a search compares one record per cycle. A read that misses is reported
// without walking. The next beat is accepted the cycle after a result is registered.
// s_axis_tready is high only while reset is released and the sequencer is idle; a
// finished result sits in the output register, so the next beat is accepted while the
// receiver stalls, and that beat's result waits until the register is taken.
// Reset (synchronous, active low) empties the log, zeroes the write slot and the
// commit counter and restores save_interval to 60. The memory is not cleared:
// only slots that have been written are ever read.
// Depends on tprl_pkg, tprl_ram, tprl_walk and assert_macros.svh.
`include "assert_macros.svh"

module timestamped_position_ring_log #(
    parameter int SLOTS       = tprl_pkg::SLOTS_DEF,
    parameter int MAX_RECORDS = tprl_pkg::MAX_RECORDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config: save_interval
    input  logic                               i_cfg_wr_en,
    input  logic [tprl_pkg::INTERVAL_W-1:0]    i_cfg_wr_data,
    // command beat
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // fix_valid[0], fix_minutes[32:1], fix_altitude[48:33], fix_latitude[64:49],
    // fix_longitude[80:65], age_index[88:81], query_minutes[120:89], zero[127:121]
    input  logic [tprl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // mode[1:0]
    input  logic [tprl_pkg::MODE_W-1:0]        s_axis_tuser,
    // result beat
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // rec_minutes[31:0], rec_altitude[47:32], rec_latitude[63:48],
    // rec_longitude[79:64], found_index[87:80], entry_count[95:88],
    // commits_since_reset[111:96]
    output logic [tprl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // hit[0]
    output logic                               m_axis_tuser
);
    import tprl_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int AGE_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WALK   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_WRITE  = 6'b001000,
        S_SEARCH = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // command held for the whole run
    logic [MODE_W-1:0]     r_mode;
    t_rec                  r_fix;
    logic [MIN_W-1:0]      r_qmin;
    logic [AGE_W-1:0]      r_target;
    logic                  r_pre;
    // log state
    logic [SLOT_W-1:0]     r_ws;
    logic [CNT_W-1:0]      r_count;
    logic [COMMIT_W-1:0]   r_commits;
    logic [INTERVAL_W-1:0] r_interval;
    // result being built
    logic                  r_hit;
    t_rec                  r_rec;
    logic [IDX_W-1:0]      r_found;
    // search read in flight
    logic                  r_rd_vld;
    logic [AGE_W-1:0]      r_rd_age;
    // output register
    logic                  r_out_vld;
    logic                  r_out_hit;
    logic [M_TDATA_W-1:0]  r_out_data;

    t_walk_ctl             walk_ctl;
    logic [SLOT_W-1:0]     walk_ptr;
    logic [AGE_W-1:0]      walk_age;

    logic                  rd_en;
    t_rec                  rd_data;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic                  commit;
    logic                  accept;
    logic                  out_load;
    logic                  issue;
    logic [AGE_W-1:0]      count_ext;
    logic [MIN_W-1:0]      time_gap;

    // unpacked command fields
    logic                  in_valid;
    t_rec                  in_fix;
    logic [IDX_W-1:0]      in_age;
    logic [MIN_W-1:0]      in_qmin;

    assign in_valid       = s_axis_tdata[0];
    assign in_fix.minutes = s_axis_tdata[32:1];
    assign in_fix.alt     = s_axis_tdata[48:33];
    assign in_fix.lat     = s_axis_tdata[64:49];
    assign in_fix.lon     = s_axis_tdata[80:65];
    assign in_age         = s_axis_tdata[88:81];
    assign in_qmin        = s_axis_tdata[120:89];

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign count_ext     = AGE_W'(r_count);
    assign issue         = (walk_age < count_ext);
    assign time_gap      = r_fix.minutes - rd_data.minutes;
    assign out_load      = (r_state == S_OUT) && (!r_out_vld || m_axis_tready);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    tprl_walk #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W),
        .AGE_W  (AGE_W)
    ) u_walk (
        .i_clk     (i_clk),
        .i_ctl     (walk_ctl),
        .i_wr_slot (r_ws),
        .o_ptr     (walk_ptr),
        .o_age     (walk_age)
    );

    tprl_ram #(
        .DEPTH (SLOTS),
        .AW    (SLOT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_fix),
        .i_rd_en   (rd_en),
        .i_rd_addr (walk_ptr),
        .o_rd_data (rd_data)
    );

    // Sequencer: next state, walker and memory strobes.
    always_comb begin
        n_state       = r_state;
        walk_ctl.load = 1'b0;
        walk_ctl.step = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        commit        = 1'b0;
        // advance before the write when the interval has passed
        wr_addr       = r_pre ? slot_inc(r_ws) : r_ws;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    walk_ctl.load = 1'b1;
                    case (s_axis_tuser)
                        MODE_STORE: begin
                            if (!in_valid) begin
                                n_state = S_OUT;
                            end else if (r_count == '0) begin
                                n_state = S_WRITE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        MODE_AGE: begin
                            n_state = (AGE_W'(in_age) < count_ext) ? S_WALK : S_OUT;
                        end
                        MODE_SEARCH: begin
                            n_state = S_SEARCH;
                        end
                        MODE_OLDEST: begin
                            n_state = (r_count != '0) ? S_WALK : S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (walk_age == r_target) begin
                    rd_en   = 1'b1;
                    n_state = S_FETCH;
                end else begin
                    walk_ctl.step = 1'b1;
                end
            end
            S_FETCH: begin
                n_state = (r_mode == MODE_STORE) ? S_WRITE : S_OUT;
            end
            S_WRITE: begin
                wr_en   = 1'b1;
                commit  = r_pre || (r_count == '0);
                n_state = S_OUT;
            end
            S_SEARCH: begin
                if (issue) begin
                    rd_en         = 1'b1;
                    walk_ctl.step = 1'b1;
                end
                if (r_rd_vld && (rd_data.minutes < r_qmin)) begin
                    n_state = S_OUT;
                end else if (!r_rd_vld && !issue) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state: sequencer, log pointers, config, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ws       <= '0;
            r_count    <= '0;
            r_commits  <= '0;
            r_interval <= SAVE_INTERVAL_RST;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end
            if (commit) begin
                r_ws      <= slot_inc(r_ws);
                r_commits <= r_commits + COMMIT_W'(1);
                if (r_count < CNT_W'(MAX_RECORDS)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            // mark the record read this cycle for next cycle's compare
            r_rd_vld <= (r_state == S_SEARCH) && issue;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: latched command and the result under construction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= s_axis_tuser;
            r_fix   <= in_fix;
            r_qmin  <= in_qmin;
            r_pre   <= 1'b0;
            r_hit   <= 1'b0;
            r_rec   <= '0;
            r_found <= '0;
            // store needs the newest record, oldest the last one in the count
            if (s_axis_tuser == MODE_OLDEST) begin
                r_target <= AGE_W'(r_count - CNT_W'(1));
            end else if (s_axis_tuser == MODE_AGE) begin
                r_target <= AGE_W'(in_age);
            end else begin
                r_target <= '0;
            end
        end
        if (r_state == S_FETCH) begin
            if (r_mode == MODE_STORE) begin
                r_pre <= (time_gap > MIN_W'(r_interval));
            end else begin
                r_hit <= 1'b1;
                r_rec <= rd_data;
            end
        end
        if (r_state == S_SEARCH) begin
            if (issue) begin
                r_rd_age <= walk_age;
            end
            if (r_rd_vld && (rd_data.minutes < r_qmin)) begin
                r_hit   <= 1'b1;
                r_rec   <= rd_data;
                r_found <= r_rd_age[IDX_W-1:0];
            end
        end
        // count and commits are final once the sequencer reaches the output step
        if (out_load) begin
            r_out_hit  <= r_hit;
            r_out_data <= {r_commits, count_ext[IDX_W-1:0], r_found,
                           r_rec.lon, r_rec.lat, r_rec.alt, r_rec.minutes};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;

    // A search never compares a record outside the committed count.
    `ASSERT_ALWAYS(a_search_in_count, i_clk, i_rst_n,
        !(r_state == S_SEARCH && r_rd_vld) || (r_rd_age < count_ext),
        "search compared a record beyond the count")
    // After a commit the log is never empty.
    `ASSERT_CLK(a_commit_fills, i_clk, i_rst_n, commit |=> (r_count != '0),
        "log empty after a commit")
    // The walker never passes its target age.
    `ASSERT_ALWAYS(a_walk_bound, i_clk, i_rst_n,
        !(r_state == S_WALK) || (walk_age <= r_target),
        "walker stepped past its target")

endmodule

FILE: tb/timestamped_position_ring_log_tb.sv
// Self-checking bench for the time-stamped position ring log: directed and random command beats.
// Holds its own model of the log and compares every result beat with it.
// Depends on tprl_pkg and the timestamped_position_ring_log top level.
`timescale 1ns / 1ps

module timestamped_position_ring_log_tb;
    import tprl_pkg::*;

    // The 1500 commands of the random part fit within this limit many times over.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASE_ITEMS = 375;
    localparam int TAIL_CYCLES = 300;
    // Receiver holds off this long once, after this many result beats.
    localparam int LONG_HOLD_AT = 300;
    localparam int LONG_HOLD_CYCLES = 2000;

    // One command beat, unpacked.
    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic                fix_valid;
        logic [MIN_W-1:0]    fix_minutes;
        logic [COORD_W-1:0]  fix_altitude;
        logic [COORD_W-1:0]  fix_latitude;
        logic [COORD_W-1:0]  fix_longitude;
        logic [IDX_W-1:0]    age_index;
        logic [MIN_W-1:0]    query_minutes;
    } t_fix_cmd;

    // One result beat, unpacked.
    typedef struct {
        logic                hit;
        logic [MIN_W-1:0]    rec_minutes;
        logic [COORD_W-1:0]  rec_altitude;
        logic [COORD_W-1:0]  rec_latitude;
        logic [COORD_W-1:0]  rec_longitude;
        logic [IDX_W-1:0]    found_index;
        logic [IDX_W-1:0]    entry_count;
        logic [COMMIT_W-1:0] commits_since_reset;
    } t_log_reply;

    // Mirror of the log plus the queue of replies still owed by the block.
    class t_ring_log_scoreboard;
        t_rec                  log_mem [SLOTS_DEF];
        bit                    written [SLOTS_DEF];
        logic [IDX_W-1:0]      write_slot;
        logic [IDX_W-1:0]      record_count;
        logic [COMMIT_W-1:0]   commit_counter;
        logic [INTERVAL_W-1:0] save_interval;
        t_log_reply            expected_replies [$];
        int                    failures;

        function new();
            foreach (log_mem[i]) begin
                log_mem[i] = '0;
                written[i] = 1'b0;
            end
            write_slot     = '0;
            record_count   = '0;
            commit_counter = '0;
            save_interval  = SAVE_INTERVAL_RST;
            failures       = 0;
        endfunction

        // SLOTS is 2**IDX_W, so the 8-bit subtraction wraps the ring.
        function logic [IDX_W-1:0] slot_back(logic [IDX_W-1:0] age);
            return write_slot - age - 1'b1;
        endfunction

        function logic [MIN_W-1:0] minutes_at(logic [IDX_W-1:0] age);
            return log_mem[slot_back(age)].minutes;
        endfunction

        function void advance();
            write_slot = write_slot + 1'b1;
            if (record_count < MAX_RECORDS_DEF)
                record_count = record_count + 1'b1;
            commit_counter = commit_counter + 1'b1;
        endfunction

        // Update the mirror for an accepted command and queue its reply.
        function void note_command(t_fix_cmd c);
            t_log_reply       r;
            t_rec             t;
            logic [MIN_W-1:0] delta;
            r = '{default: '0};
            case (c.mode)
                MODE_STORE: begin
                    if (c.fix_valid) begin
                        if (record_count != 0) begin
                            delta = c.fix_minutes - minutes_at('0);
                            if (delta > {{(MIN_W-INTERVAL_W){1'b0}}, save_interval})
                                advance();
                        end
                        log_mem[write_slot] = '{lon: c.fix_longitude, lat: c.fix_latitude,
                                                alt: c.fix_altitude, minutes: c.fix_minutes};
                        written[write_slot] = 1'b1;
                        if (record_count == 0)
                            advance();
                    end
                end
                MODE_AGE: begin
                    if (c.age_index < record_count) begin
                        r.hit = 1'b1;
                        t = log_mem[slot_back(c.age_index)];
                    end
                end
                MODE_SEARCH: begin
                    for (int i = 0; i < record_count && !r.hit; i++) begin
                        if (minutes_at(IDX_W'(i)) < c.query_minutes) begin
                            r.hit = 1'b1;
                            r.found_index = IDX_W'(i);
                            t = log_mem[slot_back(IDX_W'(i))];
                        end
                    end
                end
                default: begin
                    if (record_count != 0) begin
                        r.hit = 1'b1;
                        t = log_mem[slot_back(record_count - 1'b1)];
                    end
                end
            endcase
            if (r.hit) begin
                r.rec_minutes   = t.minutes;
                r.rec_altitude  = t.alt;
                r.rec_latitude  = t.lat;
                r.rec_longitude = t.lon;
            end
            r.entry_count         = record_count;
            r.commits_since_reset = commit_counter;
            expected_replies.push_back(r);
        endfunction

        function void match(string field, logic [MIN_W-1:0] exp, logic [MIN_W-1:0] got);
            if (got !== exp) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp, got);
                failures++;
            end
        endfunction

        // Compare a result beat against the oldest reply still owed.
        function void check_reply(t_log_reply got);
            t_log_reply exp;
            if (expected_replies.size() == 0) begin
                $error("result beat with no command outstanding");
                failures++;
                return;
            end
            exp = expected_replies.pop_front();
            match("hit", MIN_W'(exp.hit), MIN_W'(got.hit));
            match("rec_minutes", exp.rec_minutes, got.rec_minutes);
            match("rec_altitude", MIN_W'(exp.rec_altitude), MIN_W'(got.rec_altitude));
            match("rec_latitude", MIN_W'(exp.rec_latitude), MIN_W'(got.rec_latitude));
            match("rec_longitude", MIN_W'(exp.rec_longitude), MIN_W'(got.rec_longitude));
            match("found_index", MIN_W'(exp.found_index), MIN_W'(got.found_index));
            match("entry_count", MIN_W'(exp.entry_count), MIN_W'(got.entry_count));
            match("commits_since_reset", MIN_W'(exp.commits_since_reset),
                  MIN_W'(got.commits_since_reset));
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [INTERVAL_W-1:0]   i_cfg_wr_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // fix_valid, fix_minutes, fix_altitude, fix_latitude, fix_longitude,
    // age_index, query_minutes, zero pad (lowest bit first)
    logic [S_TDATA_W-1:0]    s_axis_tdata;
    // mode
    logic [MODE_W-1:0]       s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // rec_minutes, rec_altitude, rec_latitude, rec_longitude, found_index,
    // entry_count, commits_since_reset (lowest bit first)
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    // hit
    logic                    m_axis_tuser;

    t_ring_log_scoreboard ledger;
    int                   cycle_count;

    timestamped_position_ring_log dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_fix_cmd make_cmd(logic [MODE_W-1:0] mode, logic fix_valid,
                                          logic [MIN_W-1:0] fix_minutes,
                                          logic [COORD_W-1:0] alt, logic [COORD_W-1:0] lat,
                                          logic [COORD_W-1:0] lon, logic [IDX_W-1:0] age,
                                          logic [MIN_W-1:0] query);
        t_fix_cmd c;
        c.mode          = mode;
        c.fix_valid     = fix_valid;
        c.fix_minutes   = fix_minutes;
        c.fix_altitude  = alt;
        c.fix_latitude  = lat;
        c.fix_longitude = lon;
        c.age_index     = age;
        c.query_minutes = query;
        return c;
    endfunction

    // Build a random command that mostly lands on live records and times near the
    // newest one, so commits, overwrites, hits and misses all show up.
    function automatic t_fix_cmd random_command();
        t_fix_cmd         c;
        int unsigned      pick;
        int unsigned      roll;
        logic [MIN_W-1:0] newest;
        logic [IDX_W-1:0] age;
        c = make_cmd(MODE_STORE, 1'($urandom_range(0, 1)), $urandom, COORD_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom), IDX_W'($urandom), $urandom);
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        if (pick < 45) begin
            c.mode = MODE_STORE;
            c.fix_valid = ($urandom_range(0, 9) != 0);
            if (ledger.record_count != 0) begin
                newest = ledger.minutes_at('0);
                // The slot at the write pointer must hold a fix before it is committed:
                // keep the time inside the interval until it does.
                if (!ledger.written[ledger.write_slot] || roll < 20)
                    c.fix_minutes = newest + $urandom_range(0, ledger.save_interval);
                else if (roll < 90)
                    c.fix_minutes = newest + ledger.save_interval + 1 + $urandom_range(0, 5000);
            end
        end else if (pick < 65) begin
            c.mode = MODE_AGE;
            if (roll < 75 && ledger.record_count != 0)
                c.age_index = IDX_W'($urandom_range(0, ledger.record_count));
        end else if (pick < 85) begin
            c.mode = MODE_SEARCH;
            if (roll < 70 && ledger.record_count != 0) begin
                age = IDX_W'($urandom_range(0, ledger.record_count - 1));
                c.query_minutes = ledger.minutes_at(age) + $urandom_range(0, 2);
            end
        end else begin
            c.mode = MODE_OLDEST;
        end
        return c;
    endfunction

    // Offer one command beat and hold it until accepted, then log it.
    task automatic send_command(input t_fix_cmd c);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[0]      = c.fix_valid;
        d[32:1]   = c.fix_minutes;
        d[48:33]  = c.fix_altitude;
        d[64:49]  = c.fix_latitude;
        d[80:65]  = c.fix_longitude;
        d[88:81]  = c.age_index;
        d[120:89] = c.query_minutes;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= c.mode;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        ledger.note_command(c);
    endtask

    // Hold the sender until every owed reply has come back.
    task automatic wait_drained();
        while (ledger.expected_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ledger.save_interval = value;
    endtask

    // Watchdog: a hang anywhere ends the run here.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timestamped_position_ring_log_tb failed");
        $finish;
    end

    // Result side: take beats, check them, and stall on a pattern that changes every
    // 250 beats, starting with a stretch of no stalls. Once, hold off long enough for
    // the block to fill and drop s_axis_tready.
    initial begin : reply_sink
        int replies_seen;
        int hold_left;
        int stall_pct;
        replies_seen  = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                ledger.check_reply('{hit: m_axis_tuser,
                                     rec_minutes: m_axis_tdata[31:0],
                                     rec_altitude: m_axis_tdata[47:32],
                                     rec_latitude: m_axis_tdata[63:48],
                                     rec_longitude: m_axis_tdata[79:64],
                                     found_index: m_axis_tdata[87:80],
                                     entry_count: m_axis_tdata[95:88],
                                     commits_since_reset: m_axis_tdata[111:96]});
                replies_seen++;
                if (replies_seen == LONG_HOLD_AT)
                    hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case ((replies_seen / 250) % 5)
                    0: stall_pct = 0;
                    1: stall_pct = 35;
                    2: stall_pct = 80;
                    3: stall_pct = 10;
                    default: stall_pct = 55;
                endcase
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        logic [INTERVAL_W-1:0] intervals [4];
        int                    burst_left;
        int                    gap;
        bit                    gaps_on;
        ledger = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_STORE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset interval of 60 minutes.
        // Empty log: every read misses, an invalid store changes nothing.
        send_command(make_cmd(MODE_AGE, 1'b0, '0, '0, '0, '0, 8'd0, '0));
        send_command(make_cmd(MODE_OLDEST, 1'b1, '1, '1, '1, '1, '1, '1));
        send_command(make_cmd(MODE_SEARCH, 1'b0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF));
        send_command(make_cmd(MODE_STORE, 1'b0, '1, '1, '1, '1, '1, '1));
        // First fix commits after its write, skipping the time check.
        send_command(make_cmd(MODE_STORE, 1'b1, 32'hFFFF_FFF0, '1, '1, '1, '0, '0));
        // Inside the interval: overwrite the pending slot.
        send_command(make_cmd(MODE_STORE, 1'b1, 32'hFFFF_FFF5, '0, '0, '0, '0, '0));
        // Time wraps past zero; difference 80 commits before the write.
        send_command(make_cmd(MODE_STORE, 1'b1, 32'h0000_0040, 16'h1234, 16'h5678,
                              16'h9ABC, '0, '0));
        // Exactly the interval after the newest commit: no commit.
        send_command(make_cmd(MODE_STORE, 1'b1, 32'h0000_0031, 16'h0F0F, 16'hF0F0,
                              16'h55AA, '0, '0));
        // One minute past the interval: commit.
        send_command(make_cmd(MODE_STORE, 1'b1, 32'h0000_0032, 16'hAAAA, 16'h5555,
                              16'h00FF, '0, '0));
        send_command(make_cmd(MODE_STORE, 1'b0, '0, '0, '0, '0, '0, '0));
        // Reads by age: newest, oldest, one past the count, far past the count.
        send_command(make_cmd(MODE_AGE, 1'b0, '0, '0, '0, '0, 8'd0, '0));
        send_command(make_cmd(MODE_AGE, 1'b0, '0, '0, '0, '0, 8'd2, '0));
        send_command(make_cmd(MODE_AGE, 1'b0, '0, '0, '0, '0, 8'd3, '0));
        send_command(make_cmd(MODE_AGE, 1'b1, '1, '1, '1, '1, 8'd255, '1));
        send_command(make_cmd(MODE_OLDEST, 1'b0, '0, '0, '0, '0, '0, '0));
        // Searches: nothing below zero, hit at age 0, and a miss on a tied time.
        send_command(make_cmd(MODE_SEARCH, 1'b0, '0, '0, '0, '0, '0, 32'd0));
        send_command(make_cmd(MODE_SEARCH, 1'b0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF));
        send_command(make_cmd(MODE_SEARCH, 1'b0, '0, '0, '0, '0, '0, 32'h0000_0031));
        send_command(make_cmd(MODE_SEARCH, 1'b0, '0, '0, '0, '0, '0, 32'h0000_0032));
        // All-zero fix: the wrapped difference is huge, so it commits.
        send_command(make_cmd(MODE_STORE, 1'b1, '0, '0, '0, '0, '0, '0));
        send_command(make_cmd(MODE_OLDEST, 1'b0, '0, '0, '0, '0, '0, '0));
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Random part: one phase per interval setting, both extremes included.
        intervals[0] = '0;
        intervals[1] = '1;
        intervals[2] = INTERVAL_W'($urandom_range(1, 4000));
        intervals[3] = SAVE_INTERVAL_RST;
        burst_left = 0;
        for (int p = 0; p < 4; p++) begin
            write_interval(intervals[p]);
            // Phase 2 offers beats back to back.
            gaps_on = (p != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (gaps_on && burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = $urandom_range(1, 12);
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                if (burst_left > 0)
                    burst_left--;
                send_command(random_command());
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        // Let any stray result beat show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.failures == 0 && ledger.expected_replies.size() == 0)
            $display("timestamped_position_ring_log_tb passed");
        else
            $display("timestamped_position_ring_log_tb failed");
        $finish;
    end

endmodule
